// File: src/hsvrgb_pkg.sv
// Package for the HSV to RGB converter: field widths, fixed-point constants,
// hue sector codes and the sector base table. No dependencies.
package hsvrgb_pkg;

  localparam int HUE_W     = 13;
  localparam int SAT_W     = 9;
  localparam int VAL_W     = 9;
  localparam int CH_W      = 8;
  localparam int FRAC_W    = 10;
  localparam int ERR_W     = 18;
  localparam int MIX_W     = 26;
  localparam int X_W       = 12;
  localparam int NUM_LANES = 3;
  localparam int NUM_STG   = 6;

  localparam int LN_P = 0;
  localparam int LN_Q = 1;
  localparam int LN_T = 2;

  localparam logic [HUE_W-1:0]  HUE_FULL   = 13'd5760;
  localparam logic [FRAC_W-1:0] HUE_SECTOR = 10'd960;
  localparam logic [SAT_W-1:0]  UNIT       = 9'd256;
  localparam logic [ERR_W-1:0]  E_FULL     = 18'd245760;
  localparam logic [12:0]       RECIP15    = 13'd4369;
  localparam logic [4:0]        DIV_N      = 5'd15;

  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_t;

  function automatic logic [HUE_W-1:0] sec_base(input sector_t sec);
    logic [HUE_W-1:0] base;
    case (sec)
      SEC_0:   base = 13'd0;
      SEC_1:   base = 13'd960;
      SEC_2:   base = 13'd1920;
      SEC_3:   base = 13'd2880;
      SEC_4:   base = 13'd3840;
      SEC_5:   base = 13'd4800;
      default: base = 13'd0;
    endcase
    return base;
  endfunction

endpackage

// File: src/hsvrgb_if.sv
// Valid/ready channel interfaces for HSV items in and RGB items out.
// Depends on hsvrgb_pkg for field widths.
interface hsv_item_if import hsvrgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [VAL_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface rgb_item_if import hsvrgb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: src/hsv_to_rgb_converter.sv
// HSV to RGB converter top level: six-stage pipeline with per-stage valid bits.
// Depends on hsvrgb_pkg and the channel interfaces in hsvrgb_if.
//
// Usage:
//   in_px  : HSV items (hue in 1/16 degree, saturation and brightness in 256ths).
//   out_px : RGB items, 8 bits per channel, one per accepted input item, in order.
//   An item accepted into the first stage register moves through each stage register
//   in order and shows on out_px from the output register. Throughput is one item
//   per cycle while out_px takes items; the rate is set by the pipeline, with each
//   stage holding one item (sector split, s*g products, v*e products, scale by 255,
//   reciprocal multiply for the divide by 15, correction and channel select).
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When out_px stalls, the item in the output register holds; earlier stages
//   keep advancing into empty slots, and in_px.ready drops only once every
//   stage holds an item. Nothing is dropped or repeated.
//   Full circle (hue 5760) takes the last-sector assignment with fraction 0;
//   hue above 5760 reads as 0; saturation and brightness clamp at 256.
module hsv_to_rgb_converter import hsvrgb_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  hsv_item_if.sink    in_px,
  rgb_item_if.source  out_px
);

  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] en;

  always_comb begin
    en[NUM_STG-1] = !vld_r[NUM_STG-1] || out_px.ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_px.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_px.valid;
      for (int k = 1; k < NUM_STG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 1: clamp, sector and fraction
  logic [HUE_W-1:0]  h_c;
  logic [SAT_W-1:0]  s_c;
  logic [VAL_W-1:0]  v_c;
  sector_t           sec1_nxt, sec1_r;
  logic [HUE_W-1:0]  fr_wide;
  logic [FRAC_W-1:0] frac1_nxt, frac1_r;
  logic [SAT_W-1:0]  s1_r;
  logic [VAL_W-1:0]  v1_r;

  always_comb begin
    h_c = (in_px.hue > HUE_FULL) ? '0 : in_px.hue;
    s_c = (in_px.saturation > UNIT) ? UNIT : in_px.saturation;
    v_c = (in_px.brightness > UNIT) ? VAL_W'(UNIT) : in_px.brightness;
    if (h_c >= sec_base(SEC_5))      sec1_nxt = SEC_5;
    else if (h_c >= sec_base(SEC_4)) sec1_nxt = SEC_4;
    else if (h_c >= sec_base(SEC_3)) sec1_nxt = SEC_3;
    else if (h_c >= sec_base(SEC_2)) sec1_nxt = SEC_2;
    else if (h_c >= sec_base(SEC_1)) sec1_nxt = SEC_1;
    else                             sec1_nxt = SEC_0;
    fr_wide = h_c - sec_base(sec1_nxt);
    // full circle: last sector, zero fraction
    frac1_nxt = (h_c == HUE_FULL) ? '0 : fr_wide[FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec1_r  <= sec1_nxt;
      frac1_r <= frac1_nxt;
      s1_r    <= s_c;
      v1_r    <= v_c;
    end
  end

  // stage 2: e = 256*960 - s*g per lane
  logic [FRAC_W-1:0] g2[NUM_LANES];
  logic [18:0]       sg2[NUM_LANES];
  logic [ERR_W-1:0]  e2_nxt[NUM_LANES];
  logic [ERR_W-1:0]  e2_r[NUM_LANES];
  logic [VAL_W-1:0]  v2_r;
  sector_t           sec2_r;

  always_comb begin
    g2[LN_P] = HUE_SECTOR;
    g2[LN_Q] = frac1_r;
    g2[LN_T] = HUE_SECTOR - frac1_r;
    for (int k = 0; k < NUM_LANES; k++) begin
      sg2[k]    = 19'(s1_r) * 19'(g2[k]);
      e2_nxt[k] = E_FULL - sg2[k][ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      e2_r   <= e2_nxt;
      v2_r   <= v1_r;
      sec2_r <= sec1_r;
    end
  end

  // stage 3: m = v*e per lane, cv = 255*v/256
  logic [26:0]      mw3[NUM_LANES];
  logic [MIX_W-1:0] m3_nxt[NUM_LANES];
  logic [MIX_W-1:0] m3_r[NUM_LANES];
  logic [16:0]      cvw3;
  logic [CH_W-1:0]  cv3_r;
  sector_t          sec3_r;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      mw3[k]    = 27'(v2_r) * 27'(e2_r[k]);
      m3_nxt[k] = mw3[k][MIX_W-1:0];
    end
    cvw3 = {v2_r, 8'b0} - 17'(v2_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m3_r   <= m3_nxt;
      cv3_r  <= cvw3[15:8];
      sec3_r <= sec2_r;
    end
  end

  // stage 4: x = floor(255*m / 2^22)
  logic [33:0]     w4[NUM_LANES];
  logic [X_W-1:0]  x4_r[NUM_LANES];
  logic [CH_W-1:0] cv4_r;
  sector_t         sec4_r;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      w4[k] = {m3_r[k], 8'b0} - 34'(m3_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        x4_r[k] <= w4[k][33:22];
      end
      cv4_r  <= cv3_r;
      sec4_r <= sec3_r;
    end
  end

  // stage 5: quotient estimate of x / 15 by reciprocal
  logic [24:0]     qp5[NUM_LANES];
  logic [CH_W-1:0] q5_r[NUM_LANES];
  logic [X_W-1:0]  x5_r[NUM_LANES];
  logic [CH_W-1:0] cv5_r;
  sector_t         sec5_r;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      qp5[k] = 25'(x4_r[k]) * 25'(RECIP15);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        q5_r[k] <= qp5[k][23:16];
      end
      x5_r   <= x4_r;
      cv5_r  <= cv4_r;
      sec5_r <= sec4_r;
    end
  end

  // stage 6: one-step correction, channel select, output register
  logic [X_W-1:0]  mul15[NUM_LANES];
  logic [X_W-1:0]  rem6[NUM_LANES];
  logic [CH_W-1:0] c6[NUM_LANES];
  logic [CH_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [CH_W-1:0] red_r, green_r, blue_r;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      mul15[k] = {q5_r[k], 4'b0} - X_W'(q5_r[k]);
      rem6[k]  = x5_r[k] - mul15[k];
      c6[k]    = (rem6[k] >= X_W'(DIV_N)) ? q5_r[k] + 8'd1 : q5_r[k];
    end
    case (sec5_r)
      SEC_0: begin
        red_nxt = cv5_r;    green_nxt = c6[LN_T]; blue_nxt = c6[LN_P];
      end
      SEC_1: begin
        red_nxt = c6[LN_Q]; green_nxt = cv5_r;    blue_nxt = c6[LN_P];
      end
      SEC_2: begin
        red_nxt = c6[LN_P]; green_nxt = cv5_r;    blue_nxt = c6[LN_T];
      end
      SEC_3: begin
        red_nxt = c6[LN_P]; green_nxt = c6[LN_Q]; blue_nxt = cv5_r;
      end
      SEC_4: begin
        red_nxt = c6[LN_T]; green_nxt = c6[LN_P]; blue_nxt = cv5_r;
      end
      default: begin
        red_nxt = cv5_r;    green_nxt = c6[LN_P]; blue_nxt = c6[LN_Q];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_px.valid = vld_r[NUM_STG-1];
  assign out_px.red   = red_r;
  assign out_px.green = green_r;
  assign out_px.blue  = blue_r;

`ifndef SYNTH
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_px.ready |-> (vld_r == '1) && !out_px.ready)
    else $error("input stalled while pipeline has room");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (e2_r[LN_Q] <= E_FULL) && (e2_r[LN_T] <= E_FULL) &&
                 (e2_r[LN_P] <= e2_r[LN_Q]) && (e2_r[LN_P] <= e2_r[LN_T]))
    else $error("s*g term out of range");

  a_div_fix: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (rem6[LN_P] < 12'd30) && (rem6[LN_Q] < 12'd30) &&
                 (rem6[LN_T] < 12'd30))
    else $error("divide by 15 needs more than one correction");
`endif

endmodule

// File: tb/sv/hsv_to_rgb_converter_tb.sv
// Testbench for hsv_to_rgb_converter: directed table then random HSV items, random idling
// on both channels, every RGB item checked in order. Depends on hsvrgb_pkg and hsvrgb_if.
module hsv_to_rgb_converter_tb import hsvrgb_pkg::*; ();

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [VAL_W-1:0] bri;
    bit               fixed;
    rgb_t             rgb;
  } hsv_row_t;

  localparam longint unsigned CH_MAX     = 255;
  localparam longint unsigned SAT_ONE    = UNIT;
  localparam longint unsigned SECTOR_LEN = HUE_SECTOR;
  localparam longint unsigned FULL_TURN  = HUE_FULL;
  localparam int LATENCY    = 6;
  localparam int N_DIRECTED = 23;
  localparam int N_RANDOM   = 1200;
  localparam int QUIET_TAIL = 200;
  localparam int IDLE_LIMIT = 2000;

  // fixed = 1: expected RGB typed in; otherwise the predictor supplies it
  localparam hsv_row_t DIRECTED_TAB [N_DIRECTED] = '{
    '{13'd0,    9'd0,   9'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{13'd0,    9'd0,   9'd256, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{13'd0,    9'd256, 9'd256, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{13'd960,  9'd256, 9'd256, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{13'd1920, 9'd256, 9'd256, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{13'd2880, 9'd256, 9'd256, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{13'd3840, 9'd256, 9'd256, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{13'd4800, 9'd256, 9'd256, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{13'd5760, 9'd256, 9'd256, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{13'd5761, 9'd256, 9'd256, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{13'd8191, 9'd256, 9'd256, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{13'd0,    9'd511, 9'd511, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{13'd0,    9'd0,   9'd128, 1'b1, '{8'd127, 8'd127, 8'd127}},
    '{13'd5760, 9'd0,   9'd511, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{13'd5759, 9'd256, 9'd256, 1'b0, '0},
    '{13'd959,  9'd128, 9'd200, 1'b0, '0},
    '{13'd480,  9'd128, 9'd256, 1'b0, '0},
    '{13'd1440, 9'd200, 9'd255, 1'b0, '0},
    '{13'd2400, 9'd64,  9'd100, 1'b0, '0},
    '{13'd3360, 9'd255, 9'd1,   1'b0, '0},
    '{13'd4320, 9'd257, 9'd300, 1'b0, '0},
    '{13'd5280, 9'd1,   9'd256, 1'b0, '0},
    '{13'd7000, 9'd300, 9'd511, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  hsv_item_if in_px ();
  rgb_item_if out_px ();

  hsv_to_rgb_converter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_px (out_px)
  );

  rgb_t pending_rgb [$];
  int   pixels_in;
  int   pixels_out;
  int   fail_cnt;
  int   idle_cycles;
  int   gap_pct;
  bit   quiet_tail;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor(255 * v * (1 - s*g/960)) with v, s in 256ths
  function automatic logic [CH_W-1:0] channel_level(input longint unsigned v,
                                                    input longint unsigned s,
                                                    input longint unsigned g);
    longint unsigned num;
    num = CH_MAX * v * (SAT_ONE * SECTOR_LEN - s * g);
    return CH_W'(num / (SAT_ONE * SAT_ONE * SECTOR_LEN));
  endfunction

  function automatic rgb_t rgb_from_hsv(input logic [HUE_W-1:0] h,
                                        input logic [SAT_W-1:0] s,
                                        input logic [VAL_W-1:0] b);
    longint unsigned hv, sv, vv, frac;
    logic [CH_W-1:0] c_v, c_p, c_q, c_t;
    int unsigned sec;
    rgb_t px;
    hv = h;
    sv = s;
    vv = b;
    if (hv > FULL_TURN) hv = 0;
    if (sv > SAT_ONE) sv = SAT_ONE;
    if (vv > SAT_ONE) vv = SAT_ONE;
    sec  = int'(hv / SECTOR_LEN);
    frac = hv % SECTOR_LEN;
    c_v = CH_W'((CH_MAX * vv) / SAT_ONE);
    c_p = channel_level(vv, sv, SECTOR_LEN);
    c_q = channel_level(vv, sv, frac);
    c_t = channel_level(vv, sv, SECTOR_LEN - frac);
    case (sec)
      SEC_0:   px = '{c_v, c_t, c_p};
      SEC_1:   px = '{c_q, c_v, c_p};
      SEC_2:   px = '{c_p, c_v, c_t};
      SEC_3:   px = '{c_p, c_q, c_v};
      SEC_4:   px = '{c_t, c_p, c_v};
      default: px = '{c_v, c_p, c_q};  // last sector and full circle
    endcase
    return px;
  endfunction

  // called at a falling edge; returns at a falling edge after the item is taken and after any random idle gap
  task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [SAT_W-1:0] s,
                            input logic [VAL_W-1:0] b, input bit fixed, input rgb_t want);
    in_px.hue        <= h;
    in_px.saturation <= s;
    in_px.brightness <= b;
    in_px.valid      <= 1'b1;
    do @(posedge clk); while (!in_px.ready);
    pending_rgb.push_back(fixed ? want : rgb_from_hsv(h, s, b));
    pixels_in++;
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      in_px.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  initial begin
    int stall_left;
    int stall_pct;
    int cyc;
    stall_left = 0;
    stall_pct  = 0;
    cyc        = 0;
    out_px.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          default: stall_pct = 25;
        endcase
      end
      cyc++;
      if (stall_left > 0 && !quiet_tail) begin
        stall_left--;
        out_px.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_px.ready <= 1'b0;
      end else begin
        out_px.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_px.valid && out_px.ready) begin
      pixels_out++;
      if (pending_rgb.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("ERROR: unexpected RGB item %0d/%0d/%0d", out_px.red, out_px.green,
                   out_px.blue);
      end else begin
        want = pending_rgb.pop_front();
        if (out_px.red !== want.red || out_px.green !== want.green ||
            out_px.blue !== want.blue) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("ERROR: RGB item %0d expected %0d/%0d/%0d got %0d/%0d/%0d",
                     pixels_out - 1, want.red, want.green, want.blue,
                     out_px.red, out_px.green, out_px.blue);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: %0d items in, %0d out, %0d pending", pixels_in, pixels_out,
                 pending_rgb.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [HUE_W-1:0] h;
    logic [SAT_W-1:0] s;
    logic [VAL_W-1:0] b;
    int sel;
    pixels_in   = 0;
    pixels_out  = 0;
    fail_cnt    = 0;
    idle_cycles = 0;
    gap_pct     = 10;
    quiet_tail  = 1'b0;
    rst_n            = 1'b0;
    in_px.valid      = 1'b0;
    in_px.hue        = '0;
    in_px.saturation = '0;
    in_px.brightness = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_pixel(DIRECTED_TAB[i].hue, DIRECTED_TAB[i].sat, DIRECTED_TAB[i].bri,
                 DIRECTED_TAB[i].fixed, DIRECTED_TAB[i].rgb);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 40;
        endcase
      end
      quiet_tail = (i >= N_RANDOM - QUIET_TAIL);
      sel = $urandom_range(0, 99);
      if (sel < 60)
        h = HUE_W'($urandom_range(0, 5760));
      else if (sel < 75)
        h = HUE_W'(960 * $urandom_range(1, 6) - 1 + $urandom_range(0, 2));  // sector edges
      else
        h = HUE_W'($urandom_range(0, 8191));
      s = ($urandom_range(0, 4) == 0) ? SAT_W'($urandom_range(0, 511))
                                      : SAT_W'($urandom_range(0, 256));
      b = ($urandom_range(0, 4) == 0) ? VAL_W'($urandom_range(0, 511))
                                      : VAL_W'($urandom_range(0, 256));
      send_pixel(h, s, b, 1'b0, '0);
    end
    in_px.valid <= 1'b0;

    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);

    $display("Sent %0d HSV items (%0d from the directed table), checked %0d RGB items",
             pixels_in, N_DIRECTED, pixels_out);
    $display("Covered all six sectors, full circle, hue wrap and clamped S/V, %0d errors",
             fail_cnt);
    if (fail_cnt == 0 && pending_rgb.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
